// File: src/cns_pkg.sv
// Package for the conditional nesting stack.
// Item, result and stack entry types, directive and error codes.
// No dependencies.
`default_nettype none

package cns_pkg;

    typedef enum logic [2:0] {
        K_IF       = 3'd0,
        K_ELSE     = 3'd1,
        K_ENDIF    = 3'd2,
        K_SWITCH   = 3'd3,
        K_CASE     = 3'd4,
        K_ELSECASE = 3'd5,
        K_ENDCASE  = 3'd6,
        K_RESTORE  = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        CS_IF       = 3'd0,
        CS_ELSE     = 3'd1,
        CS_SWITCH   = 3'd2,
        CS_CASE     = 3'd3,
        CS_CASEELSE = 3'd4
    } t_cons;

    typedef enum logic [2:0] {
        E_NONE      = 3'd0,
        E_MISSING   = 3'd1,
        E_WRONG     = 3'd2,
        E_NOHIT     = 3'd3,
        E_FIRSTPASS = 3'd4,
        E_ARGS      = 3'd5,
        E_OVERFLOW  = 3'd6
    } t_err;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESTORE,
        ST_LOAD
    } t_state;

    localparam logic [1:0] LM_ALWAYS = 2'd0;
    localparam logic [1:0] LM_NEVER  = 2'd1;
    localparam logic [1:0] LM_INACT  = 2'd2;
    localparam logic [1:0] LM_ACT    = 2'd3;

    localparam logic [1:0] LIST_MODE_RESET = LM_NEVER;
    localparam int         NUM_CAND        = 4;

    typedef struct packed {
        logic [2:0]         kind;
        logic [3:0]         arg_count;
        logic               test_bit;
        logic               negate;
        logic [3:0]         unknown_mask;
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
        logic signed [31:0] value_c;
        logic signed [31:0] value_d;
        logic [15:0]        line_number;
        logic [6:0]         restore_level;
    } t_item;

    typedef struct packed {
        logic        assemble_enable;
        logic        list_active;
        logic        list_suppress;
        logic        shown_valid;
        logic        shown_value;
        logic [2:0]  error_code;
        logic [6:0]  nest_level;
        logic        closed_valid;
        logic [15:0] closed_line;
    } t_result;

    typedef struct packed {
        logic        saved_en;
        logic        found;
        t_cons       cons;
        logic [31:0] sw_value;
        logic [15:0] line;
    } t_entry;

    typedef struct packed {
        logic wr_top;
        logic push;
        logic pop;
    } t_stack_op;

    function automatic logic f_suppress(input logic [1:0] mode, input logic act,
                                        input logic en);
        logic sup;
        case (mode)
            LM_ALWAYS: sup = 1'b1;
            LM_NEVER:  sup = 1'b0;
            LM_INACT:  sup = !act && !en;
            LM_ACT:    sup = act || !en;
            default:   sup = 1'b0;
        endcase
        return sup;
    endfunction

endpackage

`default_nettype wire

// File: src/cns_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module cns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: src/cns_eval.sv
// Directive evaluation against the cached top entry and the enable flags.
// Depends on cns_pkg.
`default_nettype none

module cns_eval #(
    parameter int CASE_VALUES = 4
) (
    input  wire cns_pkg::t_item     i_item,
    input  wire cns_pkg::t_entry    i_top,
    input  wire logic               i_top_valid,
    input  wire logic               i_full,
    input  wire logic               i_enable,
    input  wire logic               i_active,
    input  wire logic [1:0]         i_list_mode,
    output cns_pkg::t_stack_op      o_op,
    output cns_pkg::t_entry         o_entry,
    output logic                    o_enable,
    output logic                    o_active,
    output cns_pkg::t_result        o_res
);
    import cns_pkg::*;

    logic [NUM_CAND-1:0][31:0] vals;
    logic [NUM_CAND-1:0]       hit;
    logic [NUM_CAND-1:0]       in_lim;

    always_comb begin
        vals[0] = i_item.value_a;
        vals[1] = i_item.value_b;
        vals[2] = i_item.value_c;
        vals[3] = i_item.value_d;
        for (int i = 0; i < NUM_CAND; i++) begin
            hit[i] = (i_item.unknown_mask[i] ? 32'd1 : vals[i]) == i_top.sw_value;
            in_lim[i] = (4'(i) < i_item.arg_count) && (i < CASE_VALUES);
        end
    end

    always_comb begin
        logic       expr;
        logic       eq;
        logic       fp;
        logic       en;
        logic       act;
        logic       sv;
        logic       sval;
        logic       cv;
        logic [15:0] cline;
        t_err       err;
        logic       is_if;
        logic       is_sw;

        expr  = 1'b1;
        eq    = 1'b0;
        fp    = 1'b0;
        en    = i_enable;
        act   = i_active;
        sv    = 1'b0;
        sval  = 1'b0;
        cv    = 1'b0;
        cline = '0;
        err   = E_NONE;
        o_op  = '0;
        o_entry = i_top;
        is_if = i_top_valid && (i_top.cons == CS_IF || i_top.cons == CS_ELSE);
        is_sw = i_top_valid && (i_top.cons == CS_SWITCH || i_top.cons == CS_CASE);

        case (i_item.kind)
            K_IF: begin
                act = i_enable;
                if (i_enable) begin
                    if (i_item.arg_count != 4'd1) begin
                        err = E_ARGS;
                    end else if (i_item.unknown_mask[0]) begin
                        err = E_FIRSTPASS;
                    end else begin
                        expr = i_item.negate ^ i_item.test_bit;
                    end
                    sv   = 1'b1;
                    sval = expr;
                end
                if (!i_full) begin
                    o_op.push = 1'b1;
                    o_entry   = '{saved_en: i_enable, found: expr, cons: CS_IF,
                                  sw_value: '0, line: i_item.line_number};
                    en = i_enable && expr;
                end else begin
                    err = E_OVERFLOW;
                end
            end
            K_ELSE: begin
                if (!i_top_valid || i_top.cons != CS_IF) begin
                    err = E_MISSING;
                end else if (i_item.arg_count == 4'd0) begin
                    if (i_top.saved_en) begin
                        en   = !i_top.found;
                        sv   = 1'b1;
                        sval = !i_top.found;
                    end
                    o_op.wr_top  = 1'b1;
                    o_entry.cons = CS_ELSE;
                end else if (i_item.arg_count == 4'd1) begin
                    if (!i_top.saved_en) begin
                        expr = 1'b1;
                    end else if (i_top.found) begin
                        expr = 1'b0;
                    end else if (i_item.unknown_mask[0]) begin
                        expr = 1'b1;
                        err  = E_FIRSTPASS;
                    end else begin
                        expr = i_item.negate ^ i_item.test_bit;
                    end
                    en = i_top.saved_en && expr && !i_top.found;
                    if (i_top.saved_en) begin
                        sv   = 1'b1;
                        sval = expr;
                    end
                    o_op.wr_top   = 1'b1;
                    o_entry.found = i_top.found || expr;
                end else begin
                    err = E_ARGS;
                end
                act = !i_top_valid || i_top.saved_en;
            end
            K_ENDIF: begin
                if (i_item.arg_count != 4'd0) begin
                    err = E_ARGS;
                end else if (!is_if) begin
                    err = E_MISSING;
                end else begin
                    en       = i_top.saved_en;
                    cv       = 1'b1;
                    cline    = i_top.line;
                    o_op.pop = 1'b1;
                end
                act = en;
            end
            K_SWITCH: begin
                act = i_enable;
                o_entry = '{saved_en: i_enable, found: 1'b0, cons: CS_SWITCH,
                            sw_value: 32'd1, line: i_item.line_number};
                if (i_item.arg_count != 4'd1) begin
                    if (i_enable) begin
                        err = E_ARGS;
                    end
                end else if (i_item.unknown_mask[0]) begin
                    err = E_FIRSTPASS;
                end else begin
                    o_entry.sw_value = vals[0];
                end
                if (!i_full) begin
                    o_op.push = 1'b1;
                end else begin
                    err = E_OVERFLOW;
                end
            end
            K_CASE: begin
                if (!i_top_valid) begin
                    err = E_MISSING;
                end else if (i_item.arg_count == 4'd0) begin
                    err = E_ARGS;
                end else if (!is_sw) begin
                    err = E_WRONG;
                end else begin
                    if (!i_top.saved_en) begin
                        eq = 1'b1;
                    end else if (!i_top.found) begin
                        for (int i = 0; i < NUM_CAND; i++) begin
                            if (in_lim[i] && !eq) begin
                                fp = fp | i_item.unknown_mask[i];
                                eq = hit[i];
                            end
                        end
                        if (fp) begin
                            err = E_FIRSTPASS;
                        end
                    end
                    en = i_top.saved_en && eq && !i_top.found;
                    if (i_top.saved_en) begin
                        sv   = 1'b1;
                        sval = eq && !i_top.found;
                    end
                    o_op.wr_top   = 1'b1;
                    o_entry.found = i_top.found || eq;
                    o_entry.cons  = CS_CASE;
                end
                act = !i_top_valid || i_top.saved_en;
            end
            K_ELSECASE: begin
                if (i_item.arg_count != 4'd0) begin
                    err = E_ARGS;
                end else if (!i_top_valid) begin
                    err = E_MISSING;
                end else if (!is_sw) begin
                    err = E_WRONG;
                end else begin
                    en = i_top.saved_en && !i_top.found;
                    if (i_top.saved_en) begin
                        sv   = 1'b1;
                        sval = !i_top.found;
                    end
                    o_op.wr_top   = 1'b1;
                    o_entry.found = 1'b1;
                    o_entry.cons  = CS_CASEELSE;
                end
                act = !i_top_valid || i_top.saved_en;
            end
            K_ENDCASE: begin
                if (i_item.arg_count != 4'd0) begin
                    err = E_ARGS;
                end else if (!i_top_valid) begin
                    err = E_MISSING;
                end else if (!is_sw && i_top.cons != CS_CASEELSE) begin
                    err = E_WRONG;
                end else begin
                    en = i_top.saved_en;
                    if (!i_top.found) begin
                        err = E_NOHIT;
                    end
                    cv       = 1'b1;
                    cline    = i_top.line;
                    o_op.pop = 1'b1;
                end
                act = en;
            end
            default: begin
            end
        endcase

        o_enable = en;
        o_active = act;
        o_res.assemble_enable = en;
        o_res.list_active     = act;
        o_res.list_suppress   = f_suppress(i_list_mode, act, en);
        o_res.shown_valid     = sv;
        o_res.shown_value     = sv && sval;
        o_res.error_code      = err;
        o_res.nest_level      = '0;
        o_res.closed_valid    = cv;
        o_res.closed_line     = cline;
    end

endmodule

`default_nettype wire

// File: src/conditional_nesting_stack.sv
// Top level of the conditional nesting stack: sequencer, depth counter, top cache.
// Depends on cns_pkg, cns_ram and cns_eval.
`default_nettype none

// Tracks assembler conditional directives (if/else/endif, switch/case/endcase,
// restore) with the nesting stack held in a RAM and its top entry cached in a
// register. An item is taken when start is high and busy low; its result shows
// on o_result for one cycle with o_strobe and cannot be held off. Most items
// report in the cycle after they are taken; an endif or endcase that leaves
// entries then stays busy in the load state to read the new top from RAM. A
// restore that pops reads the target level entry in the restore state and, if
// entries remain, the new top in the load state. The list_mode write channel
// is always ready; the user must write it only while the block is idle (unchecked).
module conditional_nesting_stack #(
    parameter int STACK_DEPTH = 64,
    parameter int CASE_VALUES = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire cns_pkg::t_item   i_item,
    output logic                  o_strobe,
    output cns_pkg::t_result      o_result,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [1:0]       i_cfg_data
);
    import cns_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int CW = (DW > 7) ? DW : 7;

    t_state      r_state, n_state;
    logic [DW-1:0] r_depth;
    logic [DW-1:0] r_tgt;
    logic        r_enable;
    logic        r_active;
    logic [1:0]  r_list_mode;
    logic        r_strobe;
    t_entry      r_top;
    t_result     r_res;

    t_stack_op   op;
    t_entry      wr_entry;
    logic        ev_enable;
    logic        ev_active;
    t_result     ev_res;
    t_result     acc_res;
    t_result     rest_res;

    logic          accept;
    logic          top_valid;
    logic          full;
    logic          rest_go;
    logic [DW-1:0] tgt;
    logic [DW-1:0] depth_m1;
    logic [DW-1:0] depth_m2;
    logic [DW-1:0] tgt_m1;
    logic [DW-1:0] ev_depth;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    t_entry        ram_rdata;

    assign top_valid = r_depth != '0;
    assign full      = r_depth == DW'(STACK_DEPTH);
    assign accept    = start && !busy;
    assign depth_m1  = r_depth - 1'b1;
    assign depth_m2  = r_depth - DW'(2);
    assign tgt_m1    = r_tgt - 1'b1;
    assign rest_go   = (i_item.kind == K_RESTORE) && top_valid
                       && (CW'(i_item.restore_level) != CW'(r_depth));
    assign tgt       = (CW'(i_item.restore_level) < CW'(r_depth))
                       ? DW'(i_item.restore_level) : '0;
    assign ev_depth  = op.push ? r_depth + 1'b1 : (op.pop ? depth_m1 : r_depth);

    assign ram_we    = accept && (op.push || op.wr_top);
    assign ram_waddr = op.push ? r_depth[AW-1:0] : depth_m1[AW-1:0];
    assign o_cfg_ready = 1'b1;
    assign o_strobe  = r_strobe;
    assign o_result  = r_res;

    cns_eval #(
        .CASE_VALUES (CASE_VALUES)
    ) u_eval (
        .i_item      (i_item),
        .i_top       (r_top),
        .i_top_valid (top_valid),
        .i_full      (full),
        .i_enable    (r_enable),
        .i_active    (r_active),
        .i_list_mode (r_list_mode),
        .o_op        (op),
        .o_entry     (wr_entry),
        .o_enable    (ev_enable),
        .o_active    (ev_active),
        .o_res       (ev_res)
    );

    cns_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_entry),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        acc_res            = ev_res;
        acc_res.nest_level = 7'(ev_depth);
        rest_res                 = '0;
        rest_res.assemble_enable = ram_rdata.saved_en;
        rest_res.list_active     = r_active;
        rest_res.list_suppress   = f_suppress(r_list_mode, r_active, ram_rdata.saved_en);
        rest_res.nest_level      = 7'(r_tgt);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && rest_go) begin
                    n_state = ST_RESTORE;
                end else if (accept && op.pop && (r_depth > DW'(1))) begin
                    n_state = ST_LOAD;
                end
            end
            ST_RESTORE: begin
                n_state = (r_tgt != '0) ? ST_LOAD : ST_IDLE;
            end
            ST_LOAD: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            ST_IDLE: begin
                busy      = 1'b0;
                ram_raddr = rest_go ? tgt[AW-1:0] : depth_m2[AW-1:0];
            end
            ST_RESTORE: begin
                busy      = 1'b1;
                ram_raddr = tgt_m1[AW-1:0];
            end
            default: begin
                busy      = 1'b1;
                ram_raddr = tgt_m1[AW-1:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_depth     <= '0;
            r_enable    <= 1'b1;
            r_active    <= 1'b0;
            r_list_mode <= LIST_MODE_RESET;
            r_strobe    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_list_mode <= i_cfg_data;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept && !rest_go) begin
                        r_enable <= ev_enable;
                        r_active <= ev_active;
                        r_depth  <= ev_depth;
                        r_strobe <= 1'b1;
                    end
                end
                ST_RESTORE: begin
                    r_enable <= ram_rdata.saved_en;
                    r_depth  <= r_tgt;
                    r_strobe <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_tgt <= tgt;
                    if (op.push || op.wr_top) begin
                        r_top <= wr_entry;
                    end
                    r_res <= acc_res;
                end
            end
            ST_RESTORE: begin
                r_res <= rest_res;
            end
            ST_LOAD: begin
                r_top <= ram_rdata;
            end
            default: begin
            end
        endcase
    end

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_plain_item_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_item.kind != K_RESTORE) |=> o_strobe)
        else $error("non-restore item gave no result on the next cycle");

    a_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_IDLE))
        else $error("stack write outside an accepted item");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.error_code == E_OVERFLOW) |-> full)
        else $error("overflow reported below capacity");

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Testbench for conditional_nesting_stack: directed and random directive streams, every
// result beat checked field by field against a behavioral model of the nesting stack.
// Depends on cns_pkg and the conditional_nesting_stack RTL.
module testbench;
    import cns_pkg::*;

    localparam int STACK_N     = 64;
    localparam int QUIET_LIMIT = 1000;

    // open constructs tracked by the stream generator
    localparam int OPEN_IF     = 0;
    localparam int OPEN_ELSE   = 1;
    localparam int OPEN_SW     = 2;
    localparam int OPEN_SWELSE = 3;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    logic       busy;
    t_item      i_item      = '0;
    logic       o_strobe;
    t_result    o_result;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_data  = 2'd0;

    t_item   directive_q [$];
    t_result pending_results [$];
    int      idle_pct     = 15;
    int      mismatch_cnt = 0;
    int      quiet_cycles = 0;
    logic    item_beat    = 1'b0;
    bit      timed_out    = 1'b0;

    // model of the block
    logic [1:0] mode_reg  = LIST_MODE_RESET;
    logic       en_flag   = 1'b1;
    logic       act_flag  = 1'b0;
    int         depth_cnt = 0;
    t_entry     nest_mem [STACK_N];

    conditional_nesting_stack DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic bit push_frame(input logic fnd, input t_cons cs,
                                      input logic [31:0] val, input logic [15:0] ln);
        t_entry e;
        if (depth_cnt >= STACK_N) begin
            return 1'b0;
        end
        e.saved_en = en_flag;
        e.found    = fnd;
        e.cons     = cs;
        e.sw_value = val;
        e.line     = ln;
        nest_mem[depth_cnt] = e;
        depth_cnt++;
        return 1'b1;
    endfunction

    function automatic t_result apply_directive(input t_item it);
        t_result     r;
        t_err        err;
        t_entry      top;
        logic        has_top, expr, eq, seen, sv, sval;
        logic [31:0] cand;
        logic [31:0] vals [4];
        int          lim, i, old_depth;
        r = '0;
        err = E_NONE;
        sv = 1'b0;
        sval = 1'b0;
        expr = 1'b0;
        eq = 1'b0;
        vals[0] = it.value_a;
        vals[1] = it.value_b;
        vals[2] = it.value_c;
        vals[3] = it.value_d;
        has_top = depth_cnt > 0;
        if (has_top) begin
            top = nest_mem[depth_cnt - 1];
        end else begin
            top = '0;
        end
        old_depth = depth_cnt;
        case (it.kind)
            K_IF: begin
                expr = 1'b1;
                act_flag = en_flag;
                if (en_flag) begin
                    if (it.arg_count != 4'd1) err = E_ARGS;
                    else if (it.unknown_mask[0]) err = E_FIRSTPASS;
                    else expr = it.negate ^ it.test_bit;
                    sv = 1'b1;
                    sval = expr;
                end
                if (push_frame(expr, CS_IF, 32'd0, it.line_number)) en_flag = en_flag && expr;
                else err = E_OVERFLOW;
            end
            K_ELSE: begin
                if (!has_top || top.cons != CS_IF) begin
                    err = E_MISSING;
                end else if (it.arg_count == 4'd0) begin
                    if (top.saved_en) begin
                        en_flag = !top.found;
                        sv = 1'b1;
                        sval = en_flag;
                    end
                    top.cons = CS_ELSE;
                end else if (it.arg_count == 4'd1) begin
                    if (!top.saved_en) expr = 1'b1;
                    else if (top.found) expr = 1'b0;
                    else if (it.unknown_mask[0]) begin
                        expr = 1'b1;
                        err = E_FIRSTPASS;
                    end else expr = it.negate ^ it.test_bit;
                    en_flag = top.saved_en && expr && !top.found;
                    if (top.saved_en) begin
                        sv = 1'b1;
                        sval = expr;
                    end
                    if (expr) top.found = 1'b1;
                end else begin
                    err = E_ARGS;
                end
                act_flag = !has_top || top.saved_en;
            end
            K_ENDIF: begin
                if (it.arg_count != 4'd0) begin
                    err = E_ARGS;
                end else if (!has_top || (top.cons != CS_IF && top.cons != CS_ELSE)) begin
                    err = E_MISSING;
                end else begin
                    en_flag = top.saved_en;
                    r.closed_valid = 1'b1;
                    r.closed_line = top.line;
                    depth_cnt--;
                end
                act_flag = en_flag;
            end
            K_SWITCH: begin
                cand = 32'd1;
                act_flag = en_flag;
                if (it.arg_count != 4'd1) begin
                    if (en_flag) err = E_ARGS;
                end else if (it.unknown_mask[0]) begin
                    err = E_FIRSTPASS;
                end else begin
                    cand = it.value_a;
                end
                if (!push_frame(1'b0, CS_SWITCH, cand, it.line_number)) err = E_OVERFLOW;
            end
            K_CASE: begin
                if (!has_top) begin
                    err = E_MISSING;
                end else if (it.arg_count == 4'd0) begin
                    err = E_ARGS;
                end else if (top.cons != CS_SWITCH && top.cons != CS_CASE) begin
                    err = E_WRONG;
                end else begin
                    seen = top.found;
                    if (!top.saved_en) begin
                        eq = 1'b1;
                    end else if (!seen) begin
                        lim = (it.arg_count > 4) ? 4 : int'(it.arg_count);
                        for (i = 0; i < lim && !eq; i++) begin
                            cand = vals[i];
                            if (it.unknown_mask[i]) begin
                                cand = 32'd1;
                                err = E_FIRSTPASS;
                            end
                            eq = cand == top.sw_value;
                        end
                    end
                    en_flag = top.saved_en && eq && !seen;
                    if (top.saved_en) begin
                        sv = 1'b1;
                        sval = eq && !seen;
                    end
                    if (eq) top.found = 1'b1;
                    top.cons = CS_CASE;
                end
                act_flag = !has_top || top.saved_en;
            end
            K_ELSECASE: begin
                if (it.arg_count != 4'd0) begin
                    err = E_ARGS;
                end else if (!has_top) begin
                    err = E_MISSING;
                end else if (top.cons != CS_SWITCH && top.cons != CS_CASE) begin
                    err = E_WRONG;
                end else begin
                    en_flag = top.saved_en && !top.found;
                    if (top.saved_en) begin
                        sv = 1'b1;
                        sval = !top.found;
                    end
                    top.found = 1'b1;
                    top.cons = CS_CASEELSE;
                end
                act_flag = !has_top || top.saved_en;
            end
            K_ENDCASE: begin
                if (it.arg_count != 4'd0) begin
                    err = E_ARGS;
                end else if (!has_top) begin
                    err = E_MISSING;
                end else if (top.cons != CS_SWITCH && top.cons != CS_CASE &&
                             top.cons != CS_CASEELSE) begin
                    err = E_WRONG;
                end else begin
                    en_flag = top.saved_en;
                    if (!top.found) err = E_NOHIT;
                    r.closed_valid = 1'b1;
                    r.closed_line = top.line;
                    depth_cnt--;
                end
                act_flag = en_flag;
            end
            default: begin
                while (depth_cnt > 0 && depth_cnt != int'(it.restore_level)) begin
                    en_flag = nest_mem[depth_cnt - 1].saved_en;
                    depth_cnt--;
                end
            end
        endcase
        if (has_top && depth_cnt == old_depth) nest_mem[old_depth - 1] = top;

        case (mode_reg)
            LM_ALWAYS: r.list_suppress = 1'b1;
            LM_NEVER:  r.list_suppress = 1'b0;
            LM_INACT:  r.list_suppress = !act_flag && !en_flag;
            default:   r.list_suppress = act_flag || !en_flag;
        endcase
        r.assemble_enable = en_flag;
        r.list_active = act_flag;
        r.shown_valid = sv;
        r.shown_value = sv && sval;
        r.error_code = err;
        r.nest_level = 7'(depth_cnt);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_cnt++;
        end
    endtask

    // monitor: config beats, accepted items and result beats, all sampled at the rising edge
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n) begin
            item_beat <= start && !busy;
            if (i_cfg_valid && o_cfg_ready) mode_reg = i_cfg_data;
            if (start && !busy) pending_results.push_back(apply_directive(i_item));
            if (o_strobe) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    mismatch_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("assemble_enable", 32'(want.assemble_enable),
                                32'(o_result.assemble_enable));
                    check_field("list_active", 32'(want.list_active),
                                32'(o_result.list_active));
                    check_field("list_suppress", 32'(want.list_suppress),
                                32'(o_result.list_suppress));
                    check_field("shown_valid", 32'(want.shown_valid),
                                32'(o_result.shown_valid));
                    check_field("shown_value", 32'(want.shown_value),
                                32'(o_result.shown_value));
                    check_field("error_code", 32'(want.error_code),
                                32'(o_result.error_code));
                    check_field("nest_level", 32'(want.nest_level),
                                32'(o_result.nest_level));
                    check_field("closed_valid", 32'(want.closed_valid),
                                32'(o_result.closed_valid));
                    check_field("closed_line", 32'(want.closed_line),
                                32'(o_result.closed_line));
                end
            end
            if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // driver: one directive beat at a time from directive_q, changed at the falling edge
    always @(negedge i_clk) begin : driver
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !item_beat) begin
            // hold until taken
        end else if (directive_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
            start <= 1'b1;
            i_item <= directive_q.pop_front();
        end else begin
            start <= 1'b0;
        end
    end

    function automatic logic [31:0] small_val();
        if ($urandom_range(7) == 0) return $urandom();
        return 32'($urandom_range(5)) - 32'd2;
    endfunction

    function automatic logic [3:0] rare_mask();
        if ($urandom_range(9) == 0) return 4'($urandom_range(15));
        return 4'd0;
    endfunction

    function automatic logic [3:0] cond_argc();
        if ($urandom_range(19) == 0) return 4'($urandom_range(15));
        return 4'd1;
    endfunction

    function automatic t_item make_dir(input t_kind k, input logic [3:0] argc,
                                       input logic tst, input logic neg,
                                       input logic [3:0] unk);
        t_item it;
        it.kind          = k;
        it.arg_count     = argc;
        it.test_bit      = tst;
        it.negate        = neg;
        it.unknown_mask  = unk;
        it.value_a       = small_val();
        it.value_b       = small_val();
        it.value_c       = small_val();
        it.value_d       = small_val();
        it.line_number   = 16'($urandom());
        it.restore_level = 7'($urandom_range(127));
        return it;
    endfunction

    function automatic t_item noise_item();
        t_item it;
        it = make_dir(t_kind'($urandom_range(7)), 4'($urandom_range(15)),
                      1'($urandom_range(1)), 1'($urandom_range(1)), 4'($urandom_range(15)));
        it.value_a = $urandom();
        it.value_b = $urandom();
        it.value_c = $urandom();
        it.value_d = $urandom();
        return it;
    endfunction

    task automatic load_directed();
        t_item it;
        // closers and restore on an empty stack
        directive_q.push_back(make_dir(K_ENDIF, 0, 0, 0, 0));
        directive_q.push_back(make_dir(K_ELSE, 0, 0, 0, 0));
        directive_q.push_back(make_dir(K_CASE, 1, 0, 0, 0));
        directive_q.push_back(make_dir(K_ELSECASE, 0, 0, 0, 0));
        directive_q.push_back(make_dir(K_ENDCASE, 0, 0, 0, 0));
        it = make_dir(K_RESTORE, 0, 0, 0, 0);
        it.restore_level = 7'd0;
        directive_q.push_back(it);
        // if / else chain: true, false, disabled with bad args
        it = make_dir(K_IF, 1, 1, 0, 0);
        it.line_number = 16'hFFFF;
        directive_q.push_back(it);
        it = make_dir(K_IF, 1, 1, 1, 0);
        it.line_number = 16'h0000;
        directive_q.push_back(it);
        directive_q.push_back(make_dir(K_IF, 0, 0, 0, 0));
        directive_q.push_back(make_dir(K_ENDIF, 0, 0, 0, 0));
        directive_q.push_back(make_dir(K_ELSE, 1, 0, 0, 4'b0001));
        directive_q.push_back(make_dir(K_ELSE, 2, 1, 0, 0));
        directive_q.push_back(make_dir(K_ELSE, 0, 0, 0, 0));
        directive_q.push_back(make_dir(K_CASE, 1, 0, 0, 0));
        directive_q.push_back(make_dir(K_ELSECASE, 0, 0, 0, 0));
        directive_q.push_back(make_dir(K_ENDIF, 1, 0, 0, 0));
        directive_q.push_back(make_dir(K_ENDIF, 0, 0, 0, 0));
        // switch on the most negative value, hit on the last candidate
        it = make_dir(K_SWITCH, 1, 0, 0, 0);
        it.value_a = 32'h8000_0000;
        directive_q.push_back(it);
        directive_q.push_back(make_dir(K_CASE, 0, 0, 0, 0));
        it = make_dir(K_CASE, 4, 0, 0, 0);
        it.value_a = 32'h7FFF_FFFF;
        it.value_b = 32'hFFFF_FFFF;
        it.value_c = 32'h0000_0000;
        it.value_d = 32'h8000_0000;
        directive_q.push_back(it);
        it = make_dir(K_CASE, 15, 0, 0, 0);
        it.value_a = 32'h8000_0000;
        directive_q.push_back(it);
        directive_q.push_back(make_dir(K_ELSECASE, 1, 0, 0, 0));
        directive_q.push_back(make_dir(K_ELSECASE, 0, 0, 0, 0));
        directive_q.push_back(make_dir(K_ENDCASE, 0, 0, 0, 0));
        // switch with bad args, unknown candidate taken as one
        directive_q.push_back(make_dir(K_SWITCH, 2, 0, 0, 0));
        directive_q.push_back(make_dir(K_CASE, 2, 0, 0, 4'b0011));
        directive_q.push_back(make_dir(K_SWITCH, 1, 0, 0, 4'b0001));
        directive_q.push_back(make_dir(K_ENDCASE, 0, 0, 0, 0));
        it = make_dir(K_RESTORE, 0, 0, 0, 0);
        it.restore_level = 7'd127;
        directive_q.push_back(it);
    endtask

    task automatic gen_overflow();
        t_item it;
        it = make_dir(K_RESTORE, 0, 0, 0, 0);
        it.restore_level = 7'd0;
        directive_q.push_back(it);
        repeat (STACK_N + 3) begin
            if ($urandom_range(3) == 0)
                it = make_dir(K_SWITCH, 1, 0, 0, rare_mask());
            else
                it = make_dir(K_IF, 1, 1'($urandom_range(1)), 1'($urandom_range(1)),
                              rare_mask());
            directive_q.push_back(it);
        end
        it = make_dir(K_RESTORE, 0, 0, 0, 0);
        it.restore_level = 7'(STACK_N);
        directive_q.push_back(it);
        it.restore_level = 7'($urandom_range(STACK_N - 1));
        directive_q.push_back(it);
        it.restore_level = 7'd0;
        directive_q.push_back(it);
    endtask

    // mostly well-nested if/switch constructs with random content, some noise
    task automatic gen_random(input int count);
        int    open [$];
        int    made, r;
        t_item it;
        made = 0;
        while (made < count) begin
            r = $urandom_range(99);
            if (r < 8) begin
                it = noise_item();
            end else if (r < 11) begin
                it = make_dir(K_RESTORE, 4'($urandom_range(15)), 0, 0, 0);
                if ($urandom_range(1))
                    it.restore_level = 7'($urandom_range(open.size()));
                while (open.size() > int'(it.restore_level)) void'(open.pop_back());
            end else if (open.size() == 0 || (r < 40 && open.size() < 10)) begin
                if ($urandom_range(1)) begin
                    it = make_dir(K_IF, cond_argc(), 1'($urandom_range(1)),
                                  1'($urandom_range(1)), rare_mask());
                    open.push_back(OPEN_IF);
                end else begin
                    it = make_dir(K_SWITCH, cond_argc(), 0, 0, rare_mask());
                    open.push_back(OPEN_SW);
                end
            end else begin
                r = $urandom_range(9);
                case (open[open.size() - 1])
                    OPEN_IF: begin
                        if (r < 4) begin
                            it = make_dir(K_ELSE, cond_argc(), 1'($urandom_range(1)),
                                          1'($urandom_range(1)), rare_mask());
                        end else if (r < 6) begin
                            it = make_dir(K_ELSE, 0, 0, 0, 0);
                            open[open.size() - 1] = OPEN_ELSE;
                        end else begin
                            it = make_dir(K_ENDIF, 0, 0, 0, 0);
                            void'(open.pop_back());
                        end
                    end
                    OPEN_SW: begin
                        if (r < 6) begin
                            it = make_dir(K_CASE, 0, 0, 0, rare_mask());
                            if ($urandom_range(7) == 0)
                                it.arg_count = 4'($urandom_range(15));
                            else
                                it.arg_count = 4'($urandom_range(4, 1));
                        end else if (r < 8) begin
                            it = make_dir(K_ELSECASE, 0, 0, 0, 0);
                            open[open.size() - 1] = OPEN_SWELSE;
                        end else begin
                            it = make_dir(K_ENDCASE, 0, 0, 0, 0);
                            void'(open.pop_back());
                        end
                    end
                    OPEN_ELSE: begin
                        it = make_dir(K_ENDIF, 0, 0, 0, 0);
                        void'(open.pop_back());
                    end
                    default: begin
                        it = make_dir(K_ENDCASE, 0, 0, 0, 0);
                        void'(open.pop_back());
                    end
                endcase
            end
            directive_q.push_back(it);
            made++;
        end
        while (open.size() != 0) begin
            if (open[open.size() - 1] == OPEN_IF || open[open.size() - 1] == OPEN_ELSE)
                directive_q.push_back(make_dir(K_ENDIF, 0, 0, 0, 0));
            else
                directive_q.push_back(make_dir(K_ENDCASE, 0, 0, 0, 0));
            void'(open.pop_back());
        end
    endtask

    // sender stops until every expected result is back, then the block settles
    task automatic drain();
        while (directive_q.size() != 0 || start || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [1:0] m);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : sequencer
        fork
            begin
                repeat (9) @(posedge i_clk);
                @(negedge i_clk);
                i_rst_n <= 1'b1;
                load_directed();
                drain();
                set_mode(LM_ALWAYS);
                gen_random(350);
                drain();
                set_mode(LM_ACT);
                gen_overflow();
                gen_random(300);
                drain();
                set_mode(LM_INACT);
                idle_pct = 0;
                gen_random(300);
                drain();
                idle_pct = 15;
                set_mode(LM_NEVER);
                gen_random(250);
                drain();
            end
            begin
                wait (quiet_cycles >= QUIET_LIMIT);
                timed_out = 1'b1;
            end
        join_any
        if (!timed_out && mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
src/cns_pkg.sv
src/cns_ram.sv
src/cns_eval.sv
src/conditional_nesting_stack.sv
sim/testbench.sv
